// ===== sv/c8alu_pkg.sv =====
// ---------------------------------------------------------------------------
// c8alu_pkg
// types and constants shared by the 8-bit cpu arithmetic unit
// ---------------------------------------------------------------------------
package c8alu_pkg;

    // operation codes; codes above CMD_ADDSP are unused and change nothing
    typedef enum logic [4:0] {
        CMD_ADD   = 5'd0,
        CMD_ADC   = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_ADD16 = 5'd3,
        CMD_RLC   = 5'd4,
        CMD_RRC   = 5'd5,
        CMD_RL    = 5'd6,
        CMD_RR    = 5'd7,
        CMD_SLA   = 5'd8,
        CMD_SRA   = 5'd9,
        CMD_SWAP  = 5'd10,
        CMD_SRL   = 5'd11,
        CMD_BIT   = 5'd12,
        CMD_RLCA  = 5'd13,
        CMD_RRCA  = 5'd14,
        CMD_RLA   = 5'd15,
        CMD_RRA   = 5'd16,
        CMD_DAA   = 5'd17,
        CMD_ADDSP = 5'd18
    } t_cmd;

    // distance between an accumulator rotate and its operand twin
    localparam logic [4:0] ACC_ROT_OFS = 5'd9;

    // flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // decimal adjust constants
    localparam logic [7:0] DAA_LO    = 8'h06;
    localparam logic [7:0] DAA_HI    = 8'h60;
    localparam logic [7:0] DAA_LIMIT = 8'h99;
    localparam logic [3:0] DAA_DIGIT = 4'd9;

    typedef struct packed {
        logic [4:0]        cmd;
        logic [7:0]        acc_in;
        logic [7:0]        operand;
        logic [15:0]       wide_operand;
        logic [15:0]       hl_in;
        logic [15:0]       sp_in;
        logic signed [7:0] sp_offset;
        logic [2:0]        bit_index;
        logic [3:0]        flags_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0]  acc_out;
        logic [7:0]  shifted_value;
        logic [15:0] hl_out;
        logic [15:0] sp_out;
        logic [3:0]  flags_out;
    } t_alu_out;

endpackage

// ===== sv/c8alu_core.sv =====
// ---------------------------------------------------------------------------
// c8alu_core
// combinational datapath: arithmetic, shifts, bit test, decimal adjust
// ---------------------------------------------------------------------------
module c8alu_core (
    input  c8alu_pkg::t_alu_in  i_op,
    output c8alu_pkg::t_alu_out o_res
);

    logic        w_fz, w_fn, w_fh, w_fc;
    logic        w_k;
    logic [8:0]  w_sum9;
    logic [4:0]  w_hsum5;
    logic [16:0] w_sum17;
    logic [12:0] w_hsum13;
    logic        w_is_acc;
    logic [4:0]  w_rot_op;
    logic [7:0]  w_x;
    logic [7:0]  w_r;
    logic        w_rc;
    logic [7:0]  w_corr;
    logic [7:0]  w_daa_a;
    logic        w_daa_c;
    logic [15:0] w_ext;
    logic [4:0]  w_sph;
    logic [8:0]  w_spc;

    assign w_fz = i_op.flags_in[c8alu_pkg::FLAG_Z];
    assign w_fn = i_op.flags_in[c8alu_pkg::FLAG_N];
    assign w_fh = i_op.flags_in[c8alu_pkg::FLAG_H];
    assign w_fc = i_op.flags_in[c8alu_pkg::FLAG_C];

    // 8-bit add with optional carry in
    assign w_k     = (i_op.cmd == c8alu_pkg::CMD_ADC) ? w_fc : 1'b0;
    assign w_sum9  = {1'b0, i_op.acc_in} + {1'b0, i_op.operand} + {8'd0, w_k};
    assign w_hsum5 = {1'b0, i_op.acc_in[3:0]} + {1'b0, i_op.operand[3:0]} + {4'd0, w_k};

    // 16-bit hl add, half carry out of bit 11
    assign w_sum17  = {1'b0, i_op.hl_in} + {1'b0, i_op.wide_operand};
    assign w_hsum13 = {1'b0, i_op.hl_in[11:0]} + {1'b0, i_op.wide_operand[11:0]};

    // accumulator rotates reuse the operand rotate logic
    assign w_is_acc = (i_op.cmd >= c8alu_pkg::CMD_RLCA) && (i_op.cmd <= c8alu_pkg::CMD_RRA);
    assign w_rot_op = w_is_acc ? (i_op.cmd - c8alu_pkg::ACC_ROT_OFS) : i_op.cmd;
    assign w_x      = w_is_acc ? i_op.acc_in : i_op.operand;

    always_comb begin
        case (w_rot_op)
            c8alu_pkg::CMD_RLC: begin
                w_r  = {w_x[6:0], w_x[7]};
                w_rc = w_x[7];
            end
            c8alu_pkg::CMD_RRC: begin
                w_r  = {w_x[0], w_x[7:1]};
                w_rc = w_x[0];
            end
            c8alu_pkg::CMD_RL: begin
                w_r  = {w_x[6:0], w_fc};
                w_rc = w_x[7];
            end
            c8alu_pkg::CMD_RR: begin
                w_r  = {w_fc, w_x[7:1]};
                w_rc = w_x[0];
            end
            c8alu_pkg::CMD_SLA: begin
                w_r  = {w_x[6:0], 1'b0};
                w_rc = w_x[7];
            end
            c8alu_pkg::CMD_SRA: begin
                w_r  = {w_x[7], w_x[7:1]};
                w_rc = w_x[0];
            end
            c8alu_pkg::CMD_SWAP: begin
                w_r  = {w_x[3:0], w_x[7:4]};
                w_rc = 1'b0;
            end
            default: begin
                w_r  = {1'b0, w_x[7:1]};
                w_rc = w_x[0];
            end
        endcase
    end

    // decimal adjust
    always_comb begin
        w_corr  = 8'd0;
        w_daa_c = w_fc;
        if (!w_fn) begin
            if (w_fh || (i_op.acc_in[3:0] > c8alu_pkg::DAA_DIGIT)) begin
                w_corr = w_corr | c8alu_pkg::DAA_LO;
            end
            if (w_fc || (i_op.acc_in > c8alu_pkg::DAA_LIMIT)) begin
                w_corr  = w_corr | c8alu_pkg::DAA_HI;
                w_daa_c = 1'b1;
            end
            w_daa_a = i_op.acc_in + w_corr;
        end else begin
            if (w_fh) begin
                w_corr = w_corr | c8alu_pkg::DAA_LO;
            end
            if (w_fc) begin
                w_corr = w_corr | c8alu_pkg::DAA_HI;
            end
            w_daa_a = i_op.acc_in - w_corr;
        end
    end

    // signed stack offset, flags from the unsigned low byte
    assign w_ext = {{8{i_op.sp_offset[7]}}, i_op.sp_offset};
    assign w_sph = {1'b0, i_op.sp_in[3:0]} + {1'b0, i_op.sp_offset[3:0]};
    assign w_spc = {1'b0, i_op.sp_in[7:0]} + {1'b0, i_op.sp_offset};

    always_comb begin
        o_res.acc_out       = i_op.acc_in;
        o_res.shifted_value = 8'd0;
        o_res.hl_out        = i_op.hl_in;
        o_res.sp_out        = i_op.sp_in;
        o_res.flags_out     = i_op.flags_in;
        case (i_op.cmd)
            c8alu_pkg::CMD_ADD, c8alu_pkg::CMD_ADC: begin
                o_res.acc_out   = w_sum9[7:0];
                o_res.flags_out = {(w_sum9[7:0] == 8'd0), 1'b0, w_hsum5[4], w_sum9[8]};
            end
            c8alu_pkg::CMD_SUB: begin
                o_res.acc_out   = i_op.acc_in - i_op.operand;
                o_res.flags_out = {(i_op.acc_in == i_op.operand), 1'b1,
                                   (i_op.acc_in[3:0] < i_op.operand[3:0]),
                                   (i_op.acc_in < i_op.operand)};
            end
            c8alu_pkg::CMD_ADD16: begin
                o_res.hl_out    = w_sum17[15:0];
                o_res.flags_out = {w_fz, 1'b0, w_hsum13[12], w_sum17[16]};
            end
            c8alu_pkg::CMD_RLC, c8alu_pkg::CMD_RRC, c8alu_pkg::CMD_RL,
            c8alu_pkg::CMD_RR, c8alu_pkg::CMD_SLA, c8alu_pkg::CMD_SRA,
            c8alu_pkg::CMD_SWAP, c8alu_pkg::CMD_SRL: begin
                o_res.shifted_value = w_r;
                o_res.flags_out     = {(w_r == 8'd0), 1'b0, 1'b0, w_rc};
            end
            c8alu_pkg::CMD_RLCA, c8alu_pkg::CMD_RRCA, c8alu_pkg::CMD_RLA,
            c8alu_pkg::CMD_RRA: begin
                o_res.acc_out   = w_r;
                o_res.flags_out = {1'b0, 1'b0, 1'b0, w_rc};
            end
            c8alu_pkg::CMD_BIT: begin
                o_res.flags_out = {~i_op.operand[i_op.bit_index], 1'b0, 1'b1, w_fc};
            end
            c8alu_pkg::CMD_DAA: begin
                o_res.acc_out   = w_daa_a;
                o_res.flags_out = {(w_daa_a == 8'd0), w_fn, 1'b0, w_daa_c};
            end
            c8alu_pkg::CMD_ADDSP: begin
                o_res.sp_out    = i_op.sp_in + w_ext;
                o_res.flags_out = {1'b0, 1'b0, w_sph[4], w_spc[8]};
            end
            default: begin
                o_res.acc_out = i_op.acc_in;
            end
        endcase
    end

endmodule

// ===== sv/cpu8_alu_with_flags_top.sv =====
// ---------------------------------------------------------------------------
// cpu8_alu_with_flags_top
// 8-bit cpu arithmetic unit with zero, subtract, half carry and carry flags
// ---------------------------------------------------------------------------
// usage
// - slave channel takes one operation per beat: opcode in tuser, operands
//   and incoming flags in tdata
// - master channel returns one result beat per operation, in order:
//   new accumulator, shifted value, hl, sp and flags
// - a beat is captured in an input register, the datapath works on it
//   in one pass and the answer lands in a result register
// - the result is offered once the beat has moved from the input register
//   into the result register; a stall on the master side holds it back
// - throughput: one beat per cycle while the receiver keeps tready high,
//   set by the single pass through the datapath between the two registers
// - when the receiver stalls, the result register holds and the input
//   register still takes one more beat; tready drops only when both are full
// - reset empties both registers; no result is offered until a new beat
// - no configuration and no state between operations
// ---------------------------------------------------------------------------
module cpu8_alu_with_flags_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: acc_in[7:0], operand[15:8], wide_operand[31:16], hl_in[47:32],
    //        sp_in[63:48], sp_offset[71:64], bit_index[74:72],
    //        flags_in[78:75], zero pad[79]
    input  logic [79:0] i_s_tdata,
    // tuser: cmd[4:0]
    input  logic [4:0]  i_s_tuser,
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: acc_out[7:0], shifted_value[15:8], hl_out[31:16],
    //        sp_out[47:32], flags_out[51:48], zero pad[55:52]
    output logic [55:0] o_m_tdata
);

    // input stage
    logic                 r_in_valid;
    logic                 n_in_valid;
    c8alu_pkg::t_alu_in   r_in;
    c8alu_pkg::t_alu_in   n_in;

    // result stage
    logic                 r_out_valid;
    logic                 n_out_valid;
    c8alu_pkg::t_alu_out  r_out;
    c8alu_pkg::t_alu_out  w_res;

    logic                 w_s_beat;
    logic                 w_out_ready;
    logic                 w_move;

    // result register can take a new value when empty or being drained
    assign w_out_ready = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || w_out_ready;
    assign w_s_beat    = i_s_tvalid && o_s_tready;
    // input stage moves forward into the result register
    assign w_move      = r_in_valid && w_out_ready;

    // unpack the slave beat
    always_comb begin
        n_in.cmd          = i_s_tuser;
        n_in.acc_in       = i_s_tdata[7:0];
        n_in.operand      = i_s_tdata[15:8];
        n_in.wide_operand = i_s_tdata[31:16];
        n_in.hl_in        = i_s_tdata[47:32];
        n_in.sp_in        = i_s_tdata[63:48];
        n_in.sp_offset    = i_s_tdata[71:64];
        n_in.bit_index    = i_s_tdata[74:72];
        n_in.flags_in     = i_s_tdata[78:75];
    end

    c8alu_core u_core (
        .i_op  (r_in),
        .o_res (w_res)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (w_s_beat) begin
            n_in_valid = 1'b1;
        end else if (w_move) begin
            n_in_valid = 1'b0;
        end
        if (w_move) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_beat) begin
            r_in <= n_in;
        end
        if (w_move) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out.flags_out, r_out.sp_out, r_out.hl_out,
                         r_out.shifted_value, r_out.acc_out};

`ifndef SYNTHESIS
    // an empty input stage never blocks the slave side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_s_tready)
        else $error("input stage empty but tready low");

    // a taken beat is held in the input stage next cycle
    a_beat_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_beat |=> r_in_valid)
        else $error("accepted beat lost from input stage");

    // a beat that moves forward is offered on the master side next cycle
    a_move_offered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> o_m_tvalid)
        else $error("moved beat not offered on master side");

    // shifted value stays zero for plain adds
    a_add_no_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_in.cmd == c8alu_pkg::CMD_ADD)) |-> (w_res.shifted_value == 8'd0))
        else $error("add produced a shifted value");
`endif

endmodule
